@@ hw/rtl/rdv_pkg.sv @@
package rdv_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned FactorW = 16;
  localparam logic [FactorW-1:0] FactorReset = 16'd256;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

endpackage

@@ hw/rtl/rdv_pix_if.sv @@
interface rdv_pix_if;
  logic            valid;
  logic            ready;
  rdv_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/rgb_dim_via_hsv_value_top.sv @@
// RGB dimmer through HSV value. Each pixel of 8-bit channels is converted to HSV,
// V is multiplied by cfg_data (unsigned 8.8, 256 = unchanged, saturating at
// 1.0) and the pixel is converted back with round-half-up per channel.
// One pixel is accepted every clock cycle when the output is not stalled.
// Path: an item passes FRAC_BITS + 17 registers, the first at its accepting
// edge: FRAC_BITS + 12 front stages (divider input register plus one
// stage per quotient bit of the FRAC_BITS + 11 bit hue and saturation
// quotients), one queue write and four back stages (value scale, chroma,
// channel assembly, byte rounding); it may wait in the queue in between.
// Back pressure: the front pipeline freezes when the queue could overflow;
// the back pipeline freezes when its output register is full and unread.
// Write cfg only while idle.
module rgb_dim_via_hsv_value_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rdv_pix_if.sink                      in_ch,
  rdv_pix_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [rdv_pkg::FactorW-1:0]  cfg_data
);
  import rdv_pkg::*;

  localparam int unsigned QW = 3 + FRAC_BITS + 2 * (FRAC_BITS + 1);

  // hold the dim factor
  logic [FactorW-1:0] factor_r;
  always_ff @(posedge clk) begin
    if (!rst_n) factor_r <= FactorReset;
    else if (cfg_we) factor_r <= cfg_data;
  end

  // front: advance freely; a stall freezes it with items in flight
  logic                 f_adv, f_valid;
  logic [2:0]           f_sec;
  logic [FRAC_BITS-1:0] f_frac;
  logic [FRAC_BITS:0]   f_sat, f_val;
  logic                 q_empty;
  logic [2:0]           q_count;
  logic                 q_rd;
  logic [QW-1:0]        q_rdata;

  // leave room for one arriving item
  assign f_adv = (q_count < 3'd3) || q_rd;
  assign in_ch.ready = f_adv;

  rdv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .adv(f_adv),
    .in_valid(in_ch.valid & f_adv), .in_pix(in_ch.data),
    .hsv_valid(f_valid), .hsv_sector(f_sec), .hsv_frac(f_frac),
    .hsv_sat(f_sat), .hsv_val(f_val)
  );

  rdv_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .wr(f_valid & f_adv),
    .wdata({f_sec, f_frac, f_sat, f_val}),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty), .count(q_count)
  );

  // back: advance when the output register is free or being drained
  logic   b_adv, b_valid;
  pixel_t b_pix;
  assign b_adv = !out_ch.valid || out_ch.ready;
  assign q_rd  = b_adv & !q_empty;

  rdv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .adv(b_adv), .in_valid(q_rd),
    .sector(q_rdata[QW-1 -: 3]),
    .frac(q_rdata[2*(FRAC_BITS+1) +: FRAC_BITS]),
    .sat(q_rdata[FRAC_BITS+1 +: FRAC_BITS+1]),
    .val(q_rdata[FRAC_BITS:0]),
    .factor(factor_r),
    .out_valid(b_valid), .out_pix(b_pix)
  );

  assign out_ch.valid = b_valid;
  assign out_ch.data  = b_pix;

  property p_q_bound;
    @(posedge clk) disable iff (!rst_n) q_count <= 3'd4;
  endproperty
  a_q_bound: assert property (p_q_bound) else $error("queue overflow");

  a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !q_rd) else $error("queue read while empty");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
    else $error("result changed under stall");
endmodule

@@ hw/rtl/rdv_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, plus an input register.
module rdv_divider #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 8,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic [NUM_W-1:0] quo_out,
  output logic [TAG_W-1:0] tag_out
);
  logic [NUM_W-1:0] quo_r [NUM_W+1];
  logic [DEN_W:0]   rem_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r[0] <= num_in;
      rem_r[0] <= '0;
      den_r[0] <= den_in;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] sub;
    assign trial = {rem_r[i], quo_r[i][NUM_W-1]};
    assign sub   = trial - {2'b00, den_r[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!sub[DEN_W+1]) begin
          rem_r[i+1] <= sub[DEN_W:0];
          quo_r[i+1] <= {quo_r[i][NUM_W-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= trial[DEN_W:0];
          quo_r[i+1] <= {quo_r[i][NUM_W-2:0], 1'b0};
        end
        den_r[i+1] <= den_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign quo_out = quo_r[NUM_W];
  assign tag_out = tag_r[NUM_W];
endmodule

@@ hw/rtl/rdv_front.sv @@
// Classify the pixel, find V by reciprocal multiplication, S and hue with pipelined dividers.
module rdv_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  rdv_pkg::pixel_t        in_pix,
  output logic                   hsv_valid,
  output logic [2:0]             hsv_sector,
  output logic [FRAC_BITS-1:0]   hsv_frac,
  output logic [FRAC_BITS:0]     hsv_sat,
  output logic [FRAC_BITS:0]     hsv_val
);
  import rdv_pkg::*;

  localparam int unsigned NW  = PixW + 3 + FRAC_BITS;
  localparam int unsigned LAT = NW + 1;
  localparam int unsigned VW  = FRAC_BITS + 1;
  localparam int unsigned TW  = 2 + VW;
  // 2^F = 255 * VQ + VR, so V = mx * VQ + floor(mx * VR / 255)
  localparam int unsigned VQ  = (1 << FRAC_BITS) / 255;
  localparam int unsigned VR  = (1 << FRAC_BITS) % 255;

  logic [PixW-1:0] r, g, b, mx, mn, d;
  logic [PixW+2:0] h6;
  logic            chroma;
  logic [15:0]     v_rem;
  logic [24:0]     v_corr;
  logic [VW-1:0]   v_calc;

  always_comb begin
    r = in_pix.red; g = in_pix.green; b = in_pix.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    chroma = (d != '0);
    if (mx == r)
      h6 = (g >= b) ? {3'b000, g - b} : 11'(6 * {3'b000, d} - {3'b000, b - g});
    else if (mx == g)
      h6 = 11'(2 * {3'b000, d} + {3'b000, b} - {3'b000, r});
    else
      h6 = 11'(4 * {3'b000, d} + {3'b000, r} - {3'b000, g});
    // floor(y / 255) = ((y + 1) * 257) >> 16 for y below 255 * 255
    v_rem  = 16'(mx * VR);
    v_corr = 25'((25'(v_rem) + 25'd1) * 25'd257);
    v_calc = VW'(mx * VQ) + VW'(v_corr >> 16);
  end

  logic [NW-1:0] qs, qh;
  logic [TW-1:0] tag_v;
  logic          tag_unused_h;

  // carry valid, chroma flag and V alongside the saturation quotient
  rdv_divider #(.NUM_W(NW), .DEN_W(PixW), .TAG_W(TW)) u_div_s (
    .clk, .adv,
    .num_in ({{(NW-PixW-FRAC_BITS){1'b0}}, d, {FRAC_BITS{1'b0}}}),
    .den_in ((mx == '0) ? PixW'(1) : mx),
    .tag_in ({in_valid, chroma, v_calc}),
    .quo_out(qs), .tag_out(tag_v)
  );
  rdv_divider #(.NUM_W(NW), .DEN_W(PixW), .TAG_W(1)) u_div_h (
    .clk, .adv,
    .num_in ({h6, {FRAC_BITS{1'b0}}}),
    .den_in (chroma ? d : PixW'(1)),
    .tag_in (1'b0),
    .quo_out(qh), .tag_out(tag_unused_h)
  );

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  logic [2:0] sec_raw;
  assign sec_raw = qh[FRAC_BITS+2:FRAC_BITS];

  always_comb begin
    hsv_valid = vld_r[LAT-1] & tag_v[TW-1];
    hsv_val   = tag_v[VW-1:0];
    hsv_sat   = qs[FRAC_BITS:0];
    if (!tag_v[TW-2]) begin
      hsv_sector = '0; hsv_frac = '0;
    end else if (sec_raw > 3'd5) begin
      hsv_sector = 3'd5; hsv_frac = '1;
    end else begin
      hsv_sector = sec_raw; hsv_frac = qh[FRAC_BITS-1:0];
    end
  end

  logic unused_ok;
  assign unused_ok = tag_unused_h ^ (|qs[NW-1:FRAC_BITS+1]) ^ (|qh[NW-1:FRAC_BITS+3]);
endmodule

@@ hw/rtl/rdv_queue.sv @@
// Small FIFO between front and back.
module rdv_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic [2:0]   count
);
  logic [W-1:0] mem_r [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, wr} - {2'b00, rd};
    end
  end
  assign rdata = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule

@@ hw/rtl/rdv_back.sv @@
// Scale V, rebuild RGB: four register stages.
module rdv_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [2:0]                    sector,
  input  logic [FRAC_BITS-1:0]          frac,
  input  logic [FRAC_BITS:0]            sat,
  input  logic [FRAC_BITS:0]            val,
  input  logic [rdv_pkg::FactorW-1:0]   factor,
  output logic                          out_valid,
  output rdv_pkg::pixel_t               out_pix
);
  import rdv_pkg::*;

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam logic [VW-1:0] One = VW'(1) << FRAC_BITS;

  logic [3:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[2:0], in_valid};
  end

  // stage 1: scale V
  logic [VW+FactorW-1:0] vprod;
  logic [VW-1:0] v1_r, s1_r, t1_r;
  logic [2:0] sec1_r;
  assign vprod = val * factor;
  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r   <= (vprod[VW+FactorW-1:8] > (VW+FactorW-8)'(One)) ? One : VW'(vprod >> 8);
      s1_r   <= sat;
      t1_r   <= sector[0] ? One - {1'b0, frac} : {1'b0, frac};
      sec1_r <= sector;
    end
  end

  // stage 2: chroma
  logic [2*VW-1:0] cprod;
  logic [VW-1:0] c2_r, v2_r, t2_r;
  logic [2:0] sec2_r;
  assign cprod = v1_r * s1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r <= VW'(cprod >> FRAC_BITS);
      v2_r <= v1_r; t2_r <= t1_r; sec2_r <= sec1_r;
    end
  end

  // stage 3: X and channel assembly
  logic [2*VW-1:0] xprod;
  logic [VW-1:0] x, m;
  logic [VW-1:0] cr3_r, cg3_r, cb3_r;
  assign xprod = c2_r * t2_r;
  assign x = VW'(xprod >> FRAC_BITS);
  assign m = v2_r - c2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (sec2_r)
        3'd0:    begin cr3_r <= c2_r + m; cg3_r <= x + m;    cb3_r <= m;        end
        3'd1:    begin cr3_r <= x + m;    cg3_r <= c2_r + m; cb3_r <= m;        end
        3'd2:    begin cr3_r <= m;        cg3_r <= c2_r + m; cb3_r <= x + m;    end
        3'd3:    begin cr3_r <= m;        cg3_r <= x + m;    cb3_r <= c2_r + m; end
        3'd4:    begin cr3_r <= x + m;    cg3_r <= m;        cb3_r <= c2_r + m; end
        default: begin cr3_r <= c2_r + m; cg3_r <= m;        cb3_r <= x + m;    end
      endcase
    end
  end

  function automatic logic [PixW-1:0] to_byte(input logic [VW-1:0] ch);
    logic [VW-1:0]   cl;
    logic [VW+8:0]   p;
    cl = (ch > One) ? One : ch;
    p  = (VW+9)'(cl) * (VW+9)'(255) + ((VW+9)'(1) << (FRAC_BITS-1));
    return PixW'(p >> FRAC_BITS);
  endfunction

  pixel_t pix4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pix4_r.red   <= to_byte(cr3_r);
      pix4_r.green <= to_byte(cg3_r);
      pix4_r.blue  <= to_byte(cb3_r);
    end
  end

  assign out_valid = vld_r[3];
  assign out_pix   = pix4_r;
endmodule

@@ tb/sv/tb_rgb_dim_via_hsv_value_top.sv @@
`timescale 1ns / 1ps

module tb_rgb_dim_via_hsv_value_top;
  import rdv_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SETTLE_CYCLES = FRAC_BITS + 40;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FactorW-1:0] cfg_data;

  rdv_pix_if in_ch ();
  rdv_pix_if out_ch ();

  rgb_dim_via_hsv_value_top #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // Our own copy of the factor register, kept in step with every write.
  logic [FactorW-1:0] factor_shadow;
  pixel_t dimmed_pixels[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PixW-1:0] to_byte(input longint unsigned ch,
                                              input longint unsigned one);
    longint unsigned clipped;
    clipped = (ch > one) ? one : ch;
    return PixW'((clipped * 255 + (one >> 1)) >> FRAC_BITS);
  endfunction

  // Work out the dimmed pixel in fixed point, wide enough that nothing wraps.
  function automatic pixel_t dim_pixel(input pixel_t px, input logic [FactorW-1:0] factor);
    longint unsigned one, r, g, b, mx, mn, d, v, s, sector, frac, h6, hq;
    longint unsigned c, x, m, t, cr, cg, cb;
    pixel_t res;
    one = 64'd1 << FRAC_BITS;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = 0;
    sector = 0;
    frac = 0;
    v = (mx << FRAC_BITS) / 255;
    if (mx != 0) begin
      s = (d << FRAC_BITS) / mx;
      if (d != 0) begin
        // Ties on the largest channel go to red, then green, then blue.
        if (mx == r) h6 = (g >= b) ? (g - b) : (6 * d - (b - g));
        else if (mx == g) h6 = 2 * d + b - r;
        else h6 = 4 * d + r - g;
        hq = (h6 << FRAC_BITS) / d;
        sector = hq >> FRAC_BITS;
        frac = hq & (one - 1);
        if (sector > 5) begin
          sector = 5;
          frac = one - 1;
        end
      end
    end
    v = (v * factor) >> 8;
    if (v > one) v = one;
    c = (v * s) >> FRAC_BITS;
    m = v - c;
    t = sector[0] ? (one - frac) : frac;
    x = (c * t) >> FRAC_BITS;
    case (sector)
      0: begin cr = c; cg = x; cb = 0; end
      1: begin cr = x; cg = c; cb = 0; end
      2: begin cr = 0; cg = c; cb = x; end
      3: begin cr = 0; cg = x; cb = c; end
      4: begin cr = x; cg = 0; cb = c; end
      default: begin cr = c; cg = 0; cb = x; end
    endcase
    res.red = to_byte(cr + m, one);
    res.green = to_byte(cg + m, one);
    res.blue = to_byte(cb + m, one);
    return res;
  endfunction

  // Offer one pixel, hold it until accepted, then note its expected result.
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= px;
    do @(posedge clk); while (!in_ch.ready);
    dimmed_pixels.push_back(dim_pixel(px, factor_shadow));
    @(negedge clk);
  endtask

  task automatic send_rgb(input int unsigned r, input int unsigned g, input int unsigned b);
    pixel_t px;
    px.red = PixW'(r);
    px.green = PixW'(g);
    px.blue = PixW'(b);
    send_pixel(px);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(5))
      0: begin  // grey
        px.red = PixW'($urandom);
        px.green = px.red;
        px.blue = px.red;
      end
      1: begin  // two channels tied
        px = pixel_t'(24'($urandom));
        if ($urandom_range(1)) px.green = px.red; else px.blue = px.green;
      end
      2: begin  // extremes only
        px.red = $urandom_range(1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(1) ? 8'hFF : 8'h00;
        px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: px = pixel_t'(24'($urandom));
    endcase
    return px;
  endfunction

  // Drop the input, wait for every expected pixel, then let the pipeline drain.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (dimmed_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_factor(input logic [FactorW-1:0] factor);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= factor;
    @(negedge clk);
    cfg_we <= 1'b0;
    factor_shadow = factor;
  endtask

  // Corners of the colour cube, hue boundaries, ties and the black pixel.
  task automatic test_directed();
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(0, 0, 255);
    send_rgb(255, 0, 255);
    send_rgb(255, 0, 1);
    send_rgb(200, 100, 100);
    send_rgb(100, 200, 200);
    send_rgb(1, 0, 0);
    send_rgb(1, 1, 0);
    send_rgb(254, 1, 127);
    send_rgb(85, 170, 255);
    send_rgb(170, 85, 0);
  endtask

  task automatic test_factors();
    logic [FactorW-1:0] factors[7] = '{16'd0, 16'd1, 16'd128, 16'd255, 16'd512,
                                       16'hFFFF, 16'd256};
    foreach (factors[i]) begin
      write_factor(factors[i]);
      test_directed();
    end
  endtask

  task automatic test_random(input int unsigned count, input int unsigned snd,
                             input int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 45 == 0) write_factor(FactorW'($urandom_range(3) == 0 ? $urandom
                                     : $urandom_range(512)));
      send_pixel(random_pixel());
    end
  endtask

  // Hold the receiver off while pixels keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(negedge clk);
        recv_hold = 1'b0;
      end
      begin
        for (int unsigned i = 0; i < 80; i++) send_pixel(random_pixel());
        in_ch.valid <= 1'b0;
      end
    join
  endtask

  // Receiver ready: random idling, driven at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted pixel with the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dimmed_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected pixel %h", out_ch.data);
      end else begin
        want = dimmed_pixels.pop_front();
        if (want.red !== out_ch.data.red || want.green !== out_ch.data.green ||
            want.blue !== out_ch.data.blue) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                     want.red, want.green, want.blue,
                     out_ch.data.red, out_ch.data.green, out_ch.data.blue);
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    factor_shadow = FactorReset;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_factors();
    test_backpressure();
    test_random(60, 35, 61);
    test_random(60, 61, 35);
    test_random(70, 0, 0);

    wait_idle();
    if (mismatch_count == 0 && dimmed_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rdv_pkg.sv
hw/rtl/rdv_pix_if.sv
hw/rtl/rdv_divider.sv
hw/rtl/rdv_front.sv
hw/rtl/rdv_queue.sv
hw/rtl/rdv_back.sv
hw/rtl/rgb_dim_via_hsv_value_top.sv
tb/sv/tb_rgb_dim_via_hsv_value_top.sv
